// ----- sv/psxd_pkg.sv -----
// Shared types and constants for the pair-swap XOR descrambler.
package psxd_pkg;

    // Width of the stored key length; a legal length is 1 to 127.
    localparam int LEN_W = 7;

    // Result queue between the datapath and the output port.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;

    typedef enum logic [3:0] {
        PH_LEN  = 4'b0001,
        PH_KEY  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_DROP = 4'b1000
    } t_phase;

    // What the second stage does with a beat.
    typedef enum logic [1:0] {
        K_ERR,
        K_TAIL,
        K_FIRST,
        K_PAIR
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] held;
        logic       eop;
        logic [1:0] status;
    } t_s2;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       final_res;
        logic [1:0] status;
    } t_res;

endpackage

// ----- sv/pair_swap_xor_descrambler.sv -----
// Pair-swap XOR descrambler: packet parser, key memory, result queue.
// A beat's results are formed in a registered second stage, which reads the key memory, and are then queued.
// Throughput: one input byte per cycle while the result queue has room; the key memory is read once per body byte.
// Sustained output is one result per cycle while the receiver is ready, which matches one result per body byte.
// Reset clears the parser and the result queue; the key memory is not cleared and
// needs no clearing pass, since body bytes only read key bytes written for their packet.
module pair_swap_xor_descrambler #(
    parameter int KEY_DEPTH = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_packet,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_plain_byte,
    output logic       o_final_res,
    output logic [1:0] o_status
);
    import psxd_pkg::*;

    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    // Parser state.
    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_key_len, n_key_len;
    logic [AW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_key_pos, n_key_pos;
    logic              r_odd, n_odd;
    logic [7:0]        r_held, n_held;

    // Key memory.
    logic [7:0]        key_mem [KEY_DEPTH];
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [7:0]        r_rd_data;

    // Second stage.
    logic              r_s2_valid, n_s2_valid;
    t_s2               r_s2, n_s2;
    logic [7:0]        r_key_lo;

    // Result queue.
    t_res              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_CW-1:0] r_cnt;
    logic [1:0]        push_n;
    logic              pop;
    t_res              res0, res1;

    logic              accept;
    logic              bad_len;
    logic [7:0]        pos_inc, p1_inc;
    logic [AW-1:0]     p1, p2;

    assign accept = i_valid && o_ready;
    assign bad_len = (i_data_byte == 8'd0) || i_data_byte[7]
                     || (i_data_byte >= 8'(KEY_DEPTH));

    // Key index used for the first byte of a pair, and the key index of the pair after it.
    assign pos_inc = 8'(r_key_pos) + 8'd1;
    assign p1      = (pos_inc >= 8'(r_key_len)) ? '0 : AW'(pos_inc);
    assign p1_inc  = 8'(p1) + 8'd1;
    assign p2      = (p1_inc >= 8'(r_key_len)) ? '0 : AW'(p1_inc);

    always_comb begin
        n_phase    = r_phase;
        n_key_len  = r_key_len;
        n_fill     = r_fill;
        n_key_pos  = r_key_pos;
        n_odd      = r_odd;
        n_held     = r_held;
        n_s2_valid = 1'b0;
        n_s2       = r_s2;
        n_s2.data  = i_data_byte;
        n_s2.held  = r_held;
        n_s2.eop   = i_end_of_packet;
        mem_we     = 1'b0;
        mem_addr   = r_key_pos;
        if (accept) begin
            unique case (r_phase)
                PH_LEN: begin
                    if (bad_len) begin
                        n_s2_valid  = 1'b1;
                        n_s2.kind   = K_ERR;
                        n_s2.status = ST_BAD_LEN;
                        n_phase     = i_end_of_packet ? PH_LEN : PH_DROP;
                    end else if (i_end_of_packet) begin
                        n_s2_valid  = 1'b1;
                        n_s2.kind   = K_ERR;
                        n_s2.status = ST_SHORT;
                    end else begin
                        n_key_len = i_data_byte[LEN_W-1:0];
                        n_fill    = '0;
                        n_phase   = PH_KEY;
                    end
                end
                PH_KEY: begin
                    if (i_end_of_packet) begin
                        n_s2_valid  = 1'b1;
                        n_s2.kind   = K_ERR;
                        n_s2.status = ST_SHORT;
                        n_phase     = PH_LEN;
                        n_key_len   = '0;
                        n_fill      = '0;
                    end else begin
                        mem_we   = 1'b1;
                        mem_addr = r_fill;
                        n_fill   = r_fill + AW'(1);
                        if ((8'(r_fill) + 8'd1) >= 8'(r_key_len)) begin
                            n_phase   = PH_BODY;
                            n_key_pos = '0;
                            n_odd     = 1'b0;
                        end
                    end
                end
                PH_BODY: begin
                    n_s2_valid  = 1'b1;
                    n_s2.status = ST_OK;
                    if (!r_odd) begin
                        mem_addr = r_key_pos;
                        if (i_end_of_packet) begin
                            n_s2.kind = K_TAIL;
                        end else begin
                            n_s2.kind = K_FIRST;
                            n_held    = i_data_byte;
                            n_odd     = 1'b1;
                        end
                    end else begin
                        mem_addr  = p1;
                        n_s2.kind = K_PAIR;
                        n_key_pos = p2;
                        n_odd     = 1'b0;
                        n_held    = '0;
                    end
                    if (i_end_of_packet) begin
                        n_phase   = PH_LEN;
                        n_key_len = '0;
                        n_fill    = '0;
                        n_key_pos = '0;
                        n_odd     = 1'b0;
                        n_held    = '0;
                    end
                end
                PH_DROP: begin
                    if (i_end_of_packet) begin
                        n_phase   = PH_LEN;
                        n_key_len = '0;
                        n_fill    = '0;
                    end
                end
                default: begin
                    n_phase = PH_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEN;
            r_key_len  <= '0;
            r_fill     <= '0;
            r_key_pos  <= '0;
            r_odd      <= 1'b0;
            r_held     <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_key_len  <= n_key_len;
            r_fill     <= n_fill;
            r_key_pos  <= n_key_pos;
            r_odd      <= n_odd;
            r_held     <= n_held;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            key_mem[mem_addr] <= i_data_byte;
        end
        r_rd_data <= key_mem[mem_addr];
    end

    // The key byte read with the first byte of a pair is kept for its second byte until the pair completes.
    always_ff @(posedge i_clk) begin
        if (r_s2_valid && (r_s2.kind == K_FIRST)) begin
            r_key_lo <= r_rd_data;
        end
    end

    // Results formed in the second stage; a completed pair gives two.
    always_comb begin
        res0   = '{plain_byte: 8'd0, final_res: 1'b1, status: r_s2.status};
        res1   = '{plain_byte: r_s2.held ^ r_rd_data, final_res: r_s2.eop, status: ST_OK};
        push_n = 2'd0;
        case (r_s2.kind)
            K_ERR: begin
                push_n = 2'd1;
            end
            K_TAIL: begin
                res0   = '{plain_byte: r_s2.data ^ r_rd_data, final_res: 1'b1,
                           status: ST_OK};
                push_n = 2'd1;
            end
            K_FIRST: begin
                push_n = 2'd0;
            end
            K_PAIR: begin
                res0   = '{plain_byte: r_s2.data ^ r_key_lo, final_res: 1'b0,
                           status: ST_OK};
                push_n = 2'd2;
            end
        endcase
        if (!r_s2_valid) begin
            push_n = 2'd0;
        end
    end

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_plain_byte = r_fifo[r_rd].plain_byte;
    assign o_final_res  = r_fifo[r_rd].final_res;
    assign o_status     = r_fifo[r_rd].status;

    // Room is kept for the beat in the second stage plus two results of a new beat.
    assign o_ready = ((r_cnt + FIFO_CW'(push_n)) <= FIFO_CW'(FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr + FIFO_AW'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_AW'(push_n);
            r_rd  <= r_rd + FIFO_AW'(pop);
            r_cnt <= r_cnt + FIFO_CW'(push_n) - FIFO_CW'(pop);
        end
    end

`ifndef SYNTH
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_s2_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> $past(i_valid && o_ready))
        else $error("second stage loaded without an accepted beat");

    a_key_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (8'(r_key_pos) < 8'(r_key_len)))
        else $error("key position outside key length");

    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_plain_byte == 8'd0 && o_final_res))
        else $error("error result with data or without final flag");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2.kind == K_PAIR) |-> !r_odd || $past(r_phase != PH_BODY))
        else $error("pair completed but parser still holds a byte");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the pair-swap XOR descrambler with directed and random packets and idling.
`timescale 1ns / 100ps

module tb_top;
    import psxd_pkg::*;

    localparam int KEY_DEPTH   = 128;
    localparam int PHASE_ITEMS = 515;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTS  = 100;

    typedef struct {
        logic [7:0] data;
        logic       eop;
    } t_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_end_of_packet = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_plain_byte;
    logic       o_final_res;
    logic [1:0] o_status;

    pair_swap_xor_descrambler #(
        .KEY_DEPTH(KEY_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data_byte(i_data_byte),
        .i_end_of_packet(i_end_of_packet),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_plain_byte(o_plain_byte),
        .o_final_res(o_final_res),
        .o_status(o_status)
    );

    always #10 i_clk = ~i_clk;

    // Beats waiting to be offered, and descrambled bytes waiting to come out.
    t_beat pending_beats[$];
    t_res  expected_bytes[$];

    int idle_mode = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int errors = 0;
    int rx_count = 0;
    int cycles = 0;
    int queued_items = 0;
    bit offer_busy = 1'b0;
    t_beat offered;

    // Shadow state of the packet parser.
    t_phase     ph = PH_LEN;
    logic [7:0] klen = 8'd0;
    logic [7:0] kfill = 8'd0;
    logic [7:0] kpos = 8'd0;
    logic [7:0] held = 8'd0;
    logic       odd = 1'b0;
    logic [7:0] kmem [KEY_DEPTH];

    task automatic report_error(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("error at result %0d: %s", rx_count, msg);
        end
    endtask

    task automatic add_result(input logic [7:0] b, input logic fin, input logic [1:0] st);
        t_res r;
        r.plain_byte = b;
        r.final_res = fin;
        r.status = st;
        expected_bytes.push_back(r);
    endtask

    task automatic restart_packet();
        ph = PH_LEN;
        klen = 8'd0;
        kfill = 8'd0;
        kpos = 8'd0;
        held = 8'd0;
        odd = 1'b0;
    endtask

    function automatic logic [7:0] next_key_pos(input logic [7:0] p);
        return (p + 8'd1 >= klen) ? 8'd0 : p + 8'd1;
    endfunction

    // Advances the shadow parser by one accepted beat and queues what it emits.
    task automatic descramble_beat(input logic [7:0] b, input logic eop);
        logic [7:0] p1;
        case (ph)
            PH_LEN: begin
                if (b == 8'd0 || b >= 8'd128 || int'(b) >= KEY_DEPTH) begin
                    add_result(8'd0, 1'b1, ST_BAD_LEN);
                    if (eop) restart_packet();
                    else ph = PH_DROP;
                end else if (eop) begin
                    add_result(8'd0, 1'b1, ST_SHORT);
                    restart_packet();
                end else begin
                    klen = b;
                    kfill = 8'd0;
                    ph = PH_KEY;
                end
            end
            PH_KEY: begin
                if (eop) begin
                    add_result(8'd0, 1'b1, ST_SHORT);
                    restart_packet();
                end else begin
                    kmem[kfill] = b;
                    kfill++;
                    if (kfill >= klen) begin
                        ph = PH_BODY;
                        kpos = 8'd0;
                        odd = 1'b0;
                    end
                end
            end
            PH_BODY: begin
                if (!odd) begin
                    if (eop) begin
                        add_result(b ^ kmem[kpos], 1'b1, ST_OK);
                        restart_packet();
                    end else begin
                        held = b;
                        odd = 1'b1;
                    end
                end else begin
                    // The second byte of the pair goes out first.
                    p1 = next_key_pos(kpos);
                    add_result(b ^ kmem[kpos], 1'b0, ST_OK);
                    add_result(held ^ kmem[p1], eop, ST_OK);
                    if (eop) begin
                        restart_packet();
                    end else begin
                        kpos = next_key_pos(p1);
                        odd = 1'b0;
                        held = 8'd0;
                    end
                end
            end
            default: begin
                if (eop) restart_packet();
            end
        endcase
    endtask

    task automatic add_beat(input logic [7:0] b, input logic eop, input bit counted);
        t_beat t;
        t.data = b;
        t.eop = eop;
        pending_beats.push_back(t);
        if (counted) queued_items++;
    endtask

    // Mostly well-formed packets; the rest are bad lengths and packets cut short.
    task automatic add_random_packet();
        int pick;
        int len;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            n = $urandom_range(0, 99);
            if (n < 90) len = $urandom_range(1, 8);
            else if (n < 98) len = $urandom_range(9, 40);
            else len = $urandom_range(100, 127);
            add_beat(len[7:0], 1'b0, 1'b1);
            repeat (len) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            n = $urandom_range(1, 16);
            for (int i = 1; i < n; i++) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            add_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end else if (pick < 88) begin
            if ($urandom_range(0, 3) == 0) len = 0;
            else len = $urandom_range(128, 255);
            n = $urandom_range(0, 3);
            add_beat(len[7:0], n == 0, 1'b1);
            for (int i = 0; i < n; i++) begin
                add_beat(8'($urandom_range(0, 255)), i == n - 1, 1'b0);
            end
        end else if (pick < 94) begin
            add_beat(8'($urandom_range(1, 127)), 1'b1, 1'b1);
        end else begin
            len = $urandom_range(1, 10);
            n = $urandom_range(0, len - 1);
            add_beat(len[7:0], 1'b0, 1'b1);
            repeat (n) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            add_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
    endtask

    task automatic add_directed_packets();
        // Zero length, and lengths at and above the key depth.
        add_beat(8'd0, 1'b1, 1'b1);
        add_beat(8'd255, 1'b0, 1'b1);
        add_beat(8'hA5, 1'b0, 1'b0);
        add_beat(8'h5A, 1'b0, 1'b0);
        add_beat(8'hFF, 1'b1, 1'b0);
        add_beat(8'd128, 1'b1, 1'b1);
        // Packet ends on the length byte, then on the last key byte.
        add_beat(8'd1, 1'b1, 1'b1);
        add_beat(8'd2, 1'b0, 1'b1);
        add_beat(8'h3C, 1'b0, 1'b1);
        add_beat(8'hC3, 1'b1, 1'b1);
        // One-byte key, one pair and an odd tail.
        add_beat(8'd1, 1'b0, 1'b1);
        add_beat(8'hFF, 1'b0, 1'b1);
        add_beat(8'h00, 1'b0, 1'b1);
        add_beat(8'hFF, 1'b0, 1'b1);
        add_beat(8'hA5, 1'b1, 1'b1);
        // Three-byte key so the key index wraps inside a pair.
        add_beat(8'd3, 1'b0, 1'b1);
        add_beat(8'h01, 1'b0, 1'b1);
        add_beat(8'h80, 1'b0, 1'b1);
        add_beat(8'h7F, 1'b0, 1'b1);
        add_beat(8'h11, 1'b0, 1'b1);
        add_beat(8'h22, 1'b0, 1'b1);
        add_beat(8'h33, 1'b0, 1'b1);
        add_beat(8'h44, 1'b1, 1'b1);
    endtask

    function automatic int sender_idle_pct();
        return (idle_mode == 0) ? 6 : (idle_mode == 1) ? 71 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        return (idle_mode == 0) ? 71 : (idle_mode == 1) ? 6 : 0;
    endfunction

    // Driver: one beat is held on the input until the block takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (offer_busy && i_valid && o_ready) begin
                descramble_beat(offered.data, offered.eop);
                offer_busy = 1'b0;
            end
            if (!offer_busy) begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    offered = pending_beats.pop_front();
                    offer_busy = 1'b1;
                    i_valid <= 1'b1;
                    i_data_byte <= offered.data;
                    i_end_of_packet <= offered.eop;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each beat that leaves the block and drives backpressure.
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_error($sformatf("unexpected beat: byte %0h final %0b status %0d",
                                           o_plain_byte, o_final_res, o_status));
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_plain_byte !== want.plain_byte)
                        report_error($sformatf("plain_byte %0h, expected %0h",
                                               o_plain_byte, want.plain_byte));
                    if (o_final_res !== want.final_res)
                        report_error($sformatf("final_res %0b, expected %0b",
                                               o_final_res, want.final_res));
                    if (o_status !== want.status)
                        report_error($sformatf("status %0d, expected %0d",
                                               o_status, want.status));
                end
                rx_count++;
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < KEY_DEPTH; i++) kmem[i] = 8'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int m = 0; m < 3; m++) begin
            @(negedge i_clk);
            idle_mode = m;
            // The long receiver hold-off lands where the sender never idles.
            if (m == 2) hold_req = 1'b1;
            if (m == 0) add_directed_packets();
            queued_items = 0;
            while (queued_items < PHASE_ITEMS) add_random_packet();
            while (pending_beats.size() != 0 || offer_busy) @(negedge i_clk);
        end

        while (expected_bytes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
